>>> hdl/button_debounce_press_classifier_defines.svh
// Assertion macros for the button debounce press classifier checker.
// Depends on a clk and rst being visible where the macros are used.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, idle during reset
`define BDPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define BDPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bdpc_pkg.sv
// Shared types and constants for the button debounce press classifier.
// No dependencies.
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_WIDTH      = 32;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_PRESS_LEVEL     = 2'd0,
    CFG_DEBOUNCE_TIME   = 2'd1,
    CFG_LONG_PRESS_TIME = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_event_t;

  typedef struct packed {
    logic                 pin_level;
    logic [NOW_WIDTH-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    press_event_t press_event;
    logic         is_pressed;
  } result_t;

  typedef struct packed {
    logic                 press_level;
    logic [CFG_WIDTH-1:0] debounce_time;
    logic [CFG_WIDTH-1:0] long_press_time;
  } cfg_t;

endpackage

>>> hdl/bdpc_cfg.sv
// Configuration register file of the press classifier.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_cfg import bdpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level     <= 1'b0;
      cfg.debounce_time   <= DEBOUNCE_RESET;
      cfg.long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PRESS_LEVEL:     cfg.press_level     <= cfg_data[0];
        CFG_DEBOUNCE_TIME:   cfg.debounce_time   <= cfg_data;
        CFG_LONG_PRESS_TIME: cfg.long_press_time <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

>>> hdl/bdpc_core.sv
// Debounce and press state with its one-pass update logic.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_core import bdpc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,   // commit the held word
  input  sample_t word,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int CUT_WIDTH = (TIME_WIDTH > NOW_WIDTH) ? NOW_WIDTH : TIME_WIDTH;
  localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

  logic                  last_raw, last_raw_next;
  logic                  debounced_level, debounced_level_next;
  logic [TIME_WIDTH-1:0] change_time, change_time_next;
  logic [TIME_WIDTH-1:0] press_start, press_start_next;
  logic                  pressed_flag, pressed_flag_next;
  logic                  long_done, long_done_next;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] held_time;
  logic [TIME_WIDTH-1:0] press_time;
  logic                  settled;
  press_event_t          ev;

  assign now_t = TIME_WIDTH'(word.now_ms[CUT_WIDTH-1:0]);

  always_comb begin
    last_raw_next        = word.pin_level;
    change_time_next     = (word.pin_level != last_raw) ? now_t : change_time;
    debounced_level_next = debounced_level;
    press_start_next     = press_start;
    pressed_flag_next    = pressed_flag;
    long_done_next       = long_done;
    ev                   = EV_NONE;

    held_time = now_t - change_time_next;
    settled   = CMP_WIDTH'(held_time) >= CMP_WIDTH'(cfg.debounce_time);

    if (settled && (word.pin_level != debounced_level)) begin
      debounced_level_next = word.pin_level;
      if (word.pin_level == cfg.press_level) begin
        pressed_flag_next = 1'b1;
        press_start_next  = now_t;
        long_done_next    = 1'b0;
      end else begin
        if (pressed_flag && !long_done) begin
          ev = EV_SHORT;
        end
        pressed_flag_next = 1'b0;
      end
    end

    press_time = now_t - press_start_next;
    if (settled && pressed_flag_next && !long_done_next &&
        (CMP_WIDTH'(press_time) >= CMP_WIDTH'(cfg.long_press_time))) begin
      long_done_next = 1'b1;
      ev             = EV_LONG;
    end

    res.press_event = ev;
    res.is_pressed  = pressed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw        <= 1'b0;
      debounced_level <= 1'b0;
      change_time     <= '0;
      press_start     <= '0;
      pressed_flag    <= 1'b0;
      long_done       <= 1'b0;
    end else if (advance) begin
      last_raw        <= last_raw_next;
      debounced_level <= debounced_level_next;
      change_time     <= change_time_next;
      press_start     <= press_start_next;
      pressed_flag    <= pressed_flag_next;
      long_done       <= long_done_next;
    end
  end

endmodule

>>> hdl/bdpc_out.sv
// Result output register with valid/stall handshake.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_out import bdpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    room,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t result
);

  assign room = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (room) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      result <= res;
    end
  end

endmodule

>>> hdl/button_debounce_press_classifier.sv
// Button debounce and short/long press classifier, top level.
// Depends on bdpc_pkg, bdpc_cfg, bdpc_core and bdpc_out.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample): one word per raw
//   pin sample, carrying the raw level and a wrapping millisecond timestamp.
//   result channel (result_valid / result_stall / result): exactly one word
//   per sample, the press event (none, short, long) and the debounced
//   pressed flag after that sample.
//   cfg port: cfg_we writes cfg_data to the register at cfg_index (active
//   level, debounce time, long press time). Unmapped indexes are dropped.
//   Write only while no sample is in flight.
// Timing:
//   A held sample moves into the result register once that register has
//   room. One word per cycle sustained while result_stall is low; the
//   per-sample update is a couple of timestamp subtracts and compares
//   between the two registers; press state commits as the result loads.
// Reset (rst, synchronous): both stages empty, state released with all
//   times zero, registers at active level 0, 20 ms debounce, 1000 ms long.
// Stall: while result_stall holds a full result register, the input
//   register cannot drain, so sample_stall rises once it is also full.
//   Nothing is dropped or repeated.
`timescale 1ns / 1ps

module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  sample_t                  sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  cfg_t    cfg;
  sample_t held;        // input register payload
  logic    held_valid;
  logic    room;        // result register can take a word this cycle
  logic    advance;     // held word moves into the result register
  result_t res;

  assign advance      = held_valid && room;
  assign sample_stall = held_valid && !room;

  // input register: refills in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!sample_stall) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held <= sample;
    end
  end

  bdpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdpc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (held),
    .cfg     (cfg),
    .res     (res)
  );

  bdpc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .res          (res),
    .room         (room),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> hdl/bdpc_checker.sv
// Port-level checker for the press classifier, bound to the top level.
// Depends on bdpc_pkg and button_debounce_press_classifier_defines.svh.
`timescale 1ns / 1ps
`include "button_debounce_press_classifier_defines.svh"

module bdpc_checker import bdpc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `BDPC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed")
  `BDPC_ASSERT_NOW(a_short_released, result_valid && (result.press_event == EV_SHORT), !result.is_pressed, "short press reported while still pressed")
  `BDPC_ASSERT_NOW(a_long_pressed, result_valid && (result.press_event == EV_LONG), result.is_pressed, "long press reported while released")
  `BDPC_ASSERT_NOW(a_stall_cause, sample_stall, result_valid && result_stall, "input stalled without a blocked result")

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (.*);

>>> sim/button_debounce_press_classifier_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for button_debounce_press_classifier: directed corner cases, then
// randomized bounce/press/release sequences, each result word checked against an in-bench model.
// Depends on bdpc_pkg and the RTL top button_debounce_press_classifier.

module button_debounce_press_classifier_tb;
  import bdpc_pkg::*;

  // Index 3 is not mapped to any register; writes there must be dropped.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED = 2'd3;
  // Cycles without any word moving on either channel before we give up.
  localparam int QUIET_LIMIT   = 5000;
  // Two-stage pipe; a few extra cycles catch stray words after the last one.
  localparam int TAIL_CYCLES   = 10;
  localparam int RESET_CYCLES  = 12;
  // Keep the log short if the block is badly broken.
  localparam int MAX_REPORTS   = 100;

  // Every input starts at a known value.
  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  sample_t                  sample       = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_t                  result;
  logic                     cfg_we       = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index    = '0;
  logic [CFG_WIDTH-1:0]     cfg_data     = '0;

  button_debounce_press_classifier uut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Classifier model: register copies and press state, at reset values.
  // ---------------------------------------------------------------------------
  logic                 set_active   = 1'b0;
  logic [CFG_WIDTH-1:0] set_debounce = DEBOUNCE_RESET;
  logic [CFG_WIDTH-1:0] set_long     = LONG_PRESS_RESET;

  logic                 btn_last_raw  = 1'b0;
  logic                 btn_stable    = 1'b0;
  logic [NOW_WIDTH-1:0] btn_change_ms = '0;
  logic [NOW_WIDTH-1:0] btn_press_ms  = '0;
  logic                 btn_pressed   = 1'b0;
  logic                 btn_long_done = 1'b0;

  // Words predicted for accepted samples, oldest first.
  result_t predicted_presses[$];

  // Bench bookkeeping.
  logic [NOW_WIDTH-1:0] clock_ms = '0;   // running pin timestamp
  int tx_gap_max      = 9;
  int rx_hold_max     = 9;
  int rx_hold         = 0;
  int quiet_cycles    = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int short_count     = 0;
  int long_count      = 0;
  int settings_loaded = 0;
  result_t want;

  // One step of the classifier. Elapsed times are 32-bit differences, so they
  // wrap with the timestamp. A release clears the flag before the long check,
  // so a release and a long press never land on the same sample.
  function automatic result_t classify_sample(sample_t s);
    logic [NOW_WIDTH-1:0] held;
    logic [NOW_WIDTH-1:0] pressed_for;
    result_t              r;
    r.press_event = EV_NONE;
    if (s.pin_level != btn_last_raw) begin
      btn_last_raw  = s.pin_level;
      btn_change_ms = s.now_ms;
    end
    held = s.now_ms - btn_change_ms;
    // While still bouncing: no event and no long-press check.
    if (held >= {16'd0, set_debounce}) begin
      if (s.pin_level != btn_stable) begin
        btn_stable = s.pin_level;
        if (s.pin_level == set_active) begin
          btn_pressed   = 1'b1;
          btn_press_ms  = s.now_ms;
          btn_long_done = 1'b0;
        end else begin
          if (btn_pressed && !btn_long_done) r.press_event = EV_SHORT;
          btn_pressed = 1'b0;
        end
      end
      pressed_for = s.now_ms - btn_press_ms;
      if (btn_pressed && !btn_long_done && pressed_for >= {16'd0, set_long}) begin
        btn_long_done = 1'b1;
        r.press_event = EV_LONG;
      end
    end
    r.is_pressed = btn_pressed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  // Present one sample word after a random gap and hold it until taken. Valid
  // is left high on return, so a zero gap next time gives back-to-back words.
  task automatic send_sample(logic lvl, logic [NOW_WIDTH-1:0] stamp);
    sample_t s;
    result_t r;
    int      gap;
    s.pin_level = lvl;
    s.now_ms    = stamp;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    r = classify_sample(s);
    predicted_presses.push_back(r);
    samples_sent++;
    if (r.press_event == EV_SHORT) short_count++;
    if (r.press_event == EV_LONG) long_count++;
  endtask

  // Stop sending and wait until every predicted word has come back. Always
  // waits for a clock edge first, so back-to-back register writes never put two
  // assignments on cfg_we in one step.
  task automatic drain_results();
    sample_valid <= 1'b0;
    do @(posedge clk); while (predicted_presses.size() != 0);
  endtask

  // Write all three registers on consecutive edges while the block is idle.
  // Only bit 0 of the active level word counts.
  task automatic load_settings(logic [CFG_WIDTH-1:0] act_word, logic [CFG_WIDTH-1:0] deb,
                               logic [CFG_WIDTH-1:0] lng);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRESS_LEVEL;
    cfg_data  <= act_word;
    @(posedge clk);
    cfg_index <= CFG_DEBOUNCE_TIME;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS_TIME;
    cfg_data  <= lng;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_active   = act_word[0];
    set_debounce = deb;
    set_long     = lng;
    settings_loaded++;
  endtask

  // A write to the unmapped index leaves the model untouched.
  task automatic write_unmapped(logic [CFG_WIDTH-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Contact bounce that ends on lvl: for a debounce time above 1 ms the toggles
  // come closer together than it, so only the final level can settle.
  task automatic bounce_to(logic lvl);
    int flips;
    int gap_max;
    flips   = $urandom_range(0, 4);
    gap_max = (set_debounce > 1) ? set_debounce - 1 : 1;
    for (int i = flips; i >= 0; i--) begin
      clock_ms += $urandom_range(0, gap_max);
      send_sample(lvl ^ i[0], clock_ms);
    end
  endtask

  // Keep lvl for dur ms, spread over a few samples; the last lands on dur.
  task automatic hold_level(logic lvl, int unsigned dur);
    int unsigned n;
    int unsigned step;
    n = $urandom_range(1, 4);
    for (int unsigned i = 1; i <= n; i++) begin
      step = (i == n) ? dur - (dur / n) * (n - 1) : dur / n;
      clock_ms += step;
      send_sample(lvl, clock_ms);
    end
  endtask

  // Bounce in, hold for a short, exactly-long or well-long time, bounce out
  // and settle released.
  task automatic press_sequence();
    int unsigned hold_ms;
    int unsigned pick;
    bounce_to(set_active);
    // sometimes sample right on the debounce boundary
    if ($urandom_range(0, 1)) begin
      clock_ms += set_debounce;
      send_sample(set_active, clock_ms);
    end
    pick = $urandom_range(0, 2);
    if (pick == 0) hold_ms = (set_long > 1) ? $urandom_range(0, set_long - 1) : 0;
    else if (pick == 1) hold_ms = set_long;
    else hold_ms = set_long + $urandom_range(1, set_long + 50);
    hold_level(set_active, hold_ms);
    bounce_to(!set_active);
    hold_level(!set_active, set_debounce + $urandom_range(0, 2 * set_debounce + 5));
  endtask

  // One register setting, then mostly well-formed presses with some noise:
  // random levels, repeated stamps and jumps anywhere in the 32-bit range.
  task automatic run_press_phase(int count, logic act, logic [CFG_WIDTH-1:0] deb,
                                 logic [CFG_WIDTH-1:0] lng, int tx_max, int rx_max);
    logic [CFG_WIDTH-2:0] pad;
    int                   stop_at;
    pad = (CFG_WIDTH-1)'($urandom);
    load_settings({pad, act}, deb, lng);
    tx_gap_max  = tx_max;
    rx_hold_max = rx_max;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 3);
        send_sample(1'($urandom_range(0, 1)), clock_ms);
      end else begin
        press_sequence();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: active low, 20 ms debounce, 1000 ms long. The block comes
  // up released even though the stable level equals the active level.
  task automatic test_startup_release();
    send_sample(1'b0, 32'd0);       // already at active level: no press
    send_sample(1'b0, 32'd500);
    send_sample(1'b1, 32'd510);     // leaves active level, bouncing
    send_sample(1'b1, 32'd529);     // one ms short of settling
    send_sample(1'b1, 32'd530);     // settles released, no event
    send_sample(1'b0, 32'd540);
    send_sample(1'b0, 32'd560);     // re-enters active level: press starts
    send_sample(1'b0, 32'd1559);
    send_sample(1'b0, 32'd1560);    // long press
    send_sample(1'b0, 32'd3000);    // long press only once
    send_sample(1'b1, 32'd3005);
    send_sample(1'b1, 32'd3025);    // release after a long press: no short
  endtask

  // Zero and maximum times, active high, unmapped write, timestamp extremes
  // and an active level change in the middle of a press.
  task automatic test_zero_times_and_extremes();
    load_settings(16'hFFFF, 16'd0, 16'd0);
    write_unmapped(CFG_WIDTH'($urandom));
    send_sample(1'b1, 32'hFFFF_FFFF); // press and long press on one sample
    send_sample(1'b0, 32'h0000_0000); // release across the wrap
    load_settings(16'h0001, 16'd0, 16'hFFFF);
    send_sample(1'b1, 32'd3);
    send_sample(1'b0, 32'd4);         // short press
    send_sample(1'b1, 32'd5);
    send_sample(1'b1, 32'd65539);     // one ms short of long
    send_sample(1'b1, 32'd65540);     // long press
    // active level flips while pressed; state is kept as is
    load_settings(16'hFFFE, 16'hFFFF, 16'd0);
    send_sample(1'b0, 32'd70000);
    send_sample(1'b0, 32'd135534);    // still inside max debounce
    send_sample(1'b0, 32'd135535);    // settles into new active level
    send_sample(1'b1, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_FFEF); // settles across the wrap
  endtask

  task automatic test_fast_settings();
    clock_ms = $urandom;
    run_press_phase(200, 1'b1, 16'd0, 16'd0, 9, 9);
  endtask

  task automatic test_slow_settings();
    clock_ms = $urandom;
    run_press_phase(200, 1'b0, 16'hFFFF, 16'hFFFF, 9, 9);
  endtask

  // Reset-like settings at full rate on both sides, starting just below wrap.
  task automatic test_default_settings_no_idle();
    clock_ms = 32'hFFFF_F000;
    run_press_phase(300, 1'b0, DEBOUNCE_RESET, LONG_PRESS_RESET, 0, 0);
  endtask

  // Random settings, mostly short times so long presses are common; one phase
  // with times drawn from the whole range. Idling on or off per side.
  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      clock_ms = $urandom;
      if (p == 5) begin
        run_press_phase(200, 1'($urandom_range(0, 1)), CFG_WIDTH'($urandom),
                        CFG_WIDTH'($urandom),
                        $urandom_range(0, 1) * 9, $urandom_range(0, 1) * 9);
      end else begin
        run_press_phase(200, 1'($urandom_range(0, 1)), CFG_WIDTH'($urandom_range(0, 40)),
                        CFG_WIDTH'($urandom_range(0, 300)), $urandom_range(0, 1) * 9,
                        $urandom_range(0, 1) * 9);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each accepted word, then pick the next stall stretch.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int got, int exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d (result word %0d)",
               $time, what, got, exp_val, results_checked);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (predicted_presses.size() == 0) begin
        report_mismatch("unexpected result word", result.press_event, EV_NONE);
      end else begin
        want = predicted_presses.pop_front();
        if (result.press_event !== want.press_event)
          report_mismatch("press_event", result.press_event, want.press_event);
        if (result.is_pressed !== want.is_pressed)
          report_mismatch("is_pressed", result.is_pressed, want.is_pressed);
      end
      results_checked++;
      rx_hold = $urandom_range(0, rx_hold_max);
    end
    if (rx_hold > 0) begin
      result_stall <= 1'b1;
      rx_hold--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: any word moving on either channel restarts the count.
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_startup_release();
    test_zero_times_and_extremes();
    test_fast_settings();
    test_slow_settings();
    test_default_settings_no_idle();
    test_random_settings();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d samples and %0d result words under %0d register settings,",
             samples_sent, results_checked, settings_loaded);
    $display("with %0d short and %0d long presses expected; %0d mismatches.",
             short_count, long_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/bdpc_pkg.sv
hdl/bdpc_cfg.sv
hdl/bdpc_core.sv
hdl/bdpc_out.sv
hdl/button_debounce_press_classifier.sv
hdl/bdpc_checker.sv
sim/button_debounce_press_classifier_tb.sv
